@@ design/rss_pkg.sv @@
// Shared types and constants for the record selection sort block.
// Field widths, the stored record layout and the controller/datapath links.
// No dependencies.
package rss_pkg;

  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SLOT_W   = 6;

  typedef logic [AMOUNT_W-1:0] amount_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  // one 38-bit store entry
  typedef struct packed {
    amount_t amount;
    weight_t weight;
    slot_t   slot;
  } rec_t;

  // controller -> datapath
  typedef struct packed {
    logic accept_en;   // input channel ready
    logic load;        // store the incoming record
    logic sort_init;   // pos, scan index and emit index to zero
    logic scan_rd;     // read store at scan index, advance it
    logic swap_a;      // write best record at pos
    logic swap_b;      // write pos record at best index, advance pos
    logic emit_rd;     // read store at emit index
    logic out_load;    // capture read data into output register
    logic emit_next;   // advance emit index
    logic clr_count;   // set emptied for next set
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic pass_done;   // no pass left from current pos
    logic scan_last;   // scan index at final loaded entry
    logic emit_last;   // emit index at final loaded entry
    logic out_fire;
  } status_t;

endpackage

@@ design/rss_if.sv @@
// Valid/ready channel interfaces for record input and sorted output.
// Depends on rss_pkg for the field types.
interface rss_in_if;
  logic             valid;
  logic             ready;
  rss_pkg::amount_t amount;
  rss_pkg::weight_t weight;
  logic             last_record;

  modport source (output valid, output amount, output weight, output last_record,
                  input ready);
  modport sink   (input valid, input amount, input weight, input last_record,
                  output ready);
endinterface

interface rss_out_if;
  logic             valid;
  logic             ready;
  rss_pkg::amount_t out_amount;
  rss_pkg::weight_t out_weight;
  rss_pkg::slot_t   source_slot;
  logic             end_of_run;

  modport source (output valid, output out_amount, output out_weight,
                  output source_slot, output end_of_run, input ready);
  modport sink   (input valid, input out_amount, input out_weight,
                  input source_slot, input end_of_run, output ready);
endinterface

@@ design/rss_ctrl.sv @@
// Sequencer for load, selection sort passes and sorted emission.
// Depends on rss_pkg (cmd_t, status_t).
module rss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  rss_pkg::status_t status,
  output rss_pkg::cmd_t    cmd
);
  import rss_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_START    = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_TAIL     = 8'b0000_1000,
    S_SWAP_A   = 8'b0001_0000,
    S_SWAP_B   = 8'b0010_0000,
    S_EMIT_RD  = 8'b0100_0000,
    S_EMIT_OUT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   cap_r, cap_nxt; // read data lands in the cycle after S_EMIT_RD

  always_comb begin
    state_nxt = state_r;
    cap_nxt   = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept_en = 1'b1;
        if (status.in_fire) begin
          cmd.load = 1'b1;
          if (status.in_last) begin
            cmd.sort_init = 1'b1;
            state_nxt     = S_START;
          end
        end
      end
      S_START: begin
        if (status.pass_done) state_nxt = S_EMIT_RD;
        else                  state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) state_nxt = S_TAIL;
      end
      S_TAIL:   state_nxt = S_SWAP_A;
      S_SWAP_A: begin
        cmd.swap_a = 1'b1;
        state_nxt  = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.swap_b = 1'b1;
        state_nxt  = S_START;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        cap_nxt     = 1'b1;
        state_nxt   = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.out_load = cap_r;
        if (status.out_fire) begin
          if (status.emit_last) begin
            cmd.clr_count = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
    end
  end

endmodule

@@ design/rss_datapath.sv @@
// Record store, scan/compare unit, swap writes and output register.
// Depends on rss_pkg and the rss_in_if/rss_out_if channel interfaces.
module rss_datapath #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rss_pkg::cmd_t    cmd,
  output rss_pkg::status_t status,
  rss_in_if.sink           in_ch,
  rss_out_if.source        out_ch
);
  import rss_pkg::*;

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  rec_t mem [MAX_RECORDS];

  logic [CW-1:0] count_r;
  logic [AW-1:0] pos_r, idx_r, emit_r;
  logic [AW-1:0] rd_idx_r, best_idx_r;
  logic          rd_vld_r, rd_first_r;
  rec_t          rdata_r, best_r, pos_rec_r;
  rec_t          out_r;
  logic          out_valid_r, out_last_r;

  logic          full;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  rec_t          wdata;

  assign full = (count_r == CW'(MAX_RECORDS));

  assign status.in_fire   = in_ch.valid && in_ch.ready;
  assign status.in_last   = in_ch.last_record;
  assign status.pass_done = (CW'(pos_r) + CW'(1)) >= count_r;
  assign status.scan_last = (CW'(idx_r) + CW'(1)) == count_r;
  assign status.emit_last = (CW'(emit_r) + CW'(1)) == count_r;
  assign status.out_fire  = out_valid_r && out_ch.ready;

  assign in_ch.ready = cmd.accept_en;

  // single write port shared by load and the two swap writes
  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = '{amount: in_ch.amount, weight: in_ch.weight,
              slot: SLOT_W'(count_r[AW-1:0])};
    if (cmd.load && !full) begin
      we = 1'b1;
    end else if (cmd.swap_a) begin
      we    = 1'b1;
      waddr = pos_r;
      wdata = best_r;
    end else if (cmd.swap_b) begin
      we    = 1'b1;
      waddr = best_idx_r;
      wdata = pos_rec_r;
    end
  end

  assign raddr = cmd.emit_rd ? emit_r : idx_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // counters and pass bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.clr_count)           count_r <= '0;
      else if (cmd.load && !full)  count_r <= count_r + CW'(1);
      rd_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      pos_r  <= '0;
      idx_r  <= '0;
      emit_r <= '0;
    end else begin
      if (cmd.scan_rd) idx_r <= idx_r + AW'(1);
      if (cmd.swap_b) begin
        pos_r <= pos_r + AW'(1);
        idx_r <= pos_r + AW'(1);
      end
      if (cmd.emit_next) emit_r <= emit_r + AW'(1);
    end
    rd_idx_r   <= idx_r;
    rd_first_r <= (idx_r == pos_r);
  end

  // first strictly greatest weight wins; entry at pos seeds the pass
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (rd_first_r) begin
        best_r     <= rdata_r;
        best_idx_r <= rd_idx_r;
        pos_rec_r  <= rdata_r;
      end else if (rdata_r.weight > best_r.weight) begin
        best_r     <= rdata_r;
        best_idx_r <= rd_idx_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (status.out_fire) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r      <= rdata_r;
      out_last_r <= status.emit_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_amount  = out_r.amount;
  assign out_ch.out_weight  = out_r.weight;
  assign out_ch.source_slot = out_r.slot;
  assign out_ch.end_of_run  = out_last_r;

endmodule

@@ design/record_selection_sort_desc.sv @@
// Top level of the record selection sort block.
// Depends on rss_pkg, rss_if, rss_ctrl and rss_datapath.
//
// Records are taken one per cycle while the block is idle and written to a
// MAX_RECORDS-entry store in arrival order; records beyond a full store are
// dropped. The record flagged last_record starts an in-place selection sort by
// weight, descending, ties kept in store order at the start of each pass.
// Each pass scans from pos to the last loaded entry, one entry per cycle,
// through the single read port of the store. Each result is then read,
// captured and transferred before the next one is read, with the source
// slot and an end_of_run flag on the final one; no new record is taken
// until the run has been delivered.
module record_selection_sort_desc #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  rss_in_if.sink    in_ch,
  rss_out_if.source out_ch
);
  import rss_pkg::*;

  cmd_t    cmd;
  status_t status;

  rss_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  rss_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // never take records while a result is pending
  a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  // final result of the run returns the block to loading
  a_idle_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.end_of_run) |=> in_ch.ready)
    else $error("block not idle after end of run");

  // mid-run transfer keeps the block emitting
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.end_of_run) |=> !in_ch.ready)
    else $error("input reopened before end of run");

  // a last record always starts the sort rather than further loading
  a_sort_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_record) |=> !in_ch.ready)
    else $error("still loading after last record");

endmodule

@@ tb/sv/record_selection_sort_desc_tb.sv @@
// Testbench for record_selection_sort_desc: random record sets in, sorted runs out.
// Depends on rss_pkg, rss_in_if/rss_out_if and the record_selection_sort_desc RTL.
// A scoreboard class re-sorts each accepted set and checks every transfer.
module record_selection_sort_desc_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rss_pkg::*;

  localparam int unsigned REC_DEPTH = 64;

  typedef struct {
    rec_t rec;
    logic end_of_run;
  } sorted_rec_t;

  class sorted_run_board;
    rec_t        loaded[$];
    sorted_rec_t pending[$];
    int          errors;
    int          checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // records past a full store are dropped; a last marker still closes the set
    function void note_record(amount_t a, weight_t w, logic last);
      rec_t        r;
      rec_t        tmp;
      sorted_rec_t o;
      int          best;
      if (loaded.size() < REC_DEPTH) begin
        r.amount = a;
        r.weight = w;
        r.slot   = slot_t'(loaded.size());
        loaded.push_back(r);
      end
      if (last) begin
        for (int pos = 0; pos < loaded.size(); pos++) begin
          best = pos;
          // strict compare: earliest of equal weights wins the pass
          for (int i = pos + 1; i < loaded.size(); i++)
            if (loaded[i].weight > loaded[best].weight) best = i;
          if (best != pos) begin
            tmp          = loaded[pos];
            loaded[pos]  = loaded[best];
            loaded[best] = tmp;
          end
        end
        foreach (loaded[k]) begin
          o.rec        = loaded[k];
          o.end_of_run = (k == loaded.size() - 1);
          pending.push_back(o);
        end
        loaded.delete();
      end
    endfunction

    function void check_result(amount_t a, weight_t w, slot_t s, logic eor);
      sorted_rec_t o;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer amount %h weight %h slot %0d end %b",
                 $time, a, w, s, eor);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (a !== o.rec.amount) begin
        $display("%0t: out_amount expected %h actual %h", $time, o.rec.amount, a);
        errors++;
      end
      if (w !== o.rec.weight) begin
        $display("%0t: out_weight expected %h actual %h", $time, o.rec.weight, w);
        errors++;
      end
      if (s !== o.rec.slot) begin
        $display("%0t: source_slot expected %0d actual %0d", $time, o.rec.slot, s);
        errors++;
      end
      if (eor !== o.end_of_run) begin
        $display("%0t: end_of_run expected %b actual %b", $time, o.end_of_run, eor);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rss_in_if  in_if ();
  rss_out_if out_if ();

  record_selection_sort_desc #(
    .MAX_RECORDS(REC_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  sorted_run_board sb = new();
  int items_sent = 0;
  bit pressure_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // caller sits just after a falling edge; returns just after one
  task automatic send_record(input amount_t a, input weight_t w, input logic last);
    bit gaps_on;
    gaps_on = !(items_sent >= 120 && items_sent < 200);
    while (gaps_on && $urandom_range(0, 99) < 18) begin
      in_if.valid       <= 1'b0;
      in_if.amount      <= amount_t'($urandom);
      in_if.weight      <= weight_t'($urandom);
      in_if.last_record <= 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.amount      <= a;
    in_if.weight      <= w;
    in_if.last_record <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_record(a, w, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_set(input int n);
    int      mode;
    weight_t w;
    mode = $urandom_range(0, 2);
    for (int k = 0; k < n; k++) begin
      case (mode)
        0:       w = weight_t'($urandom_range(0, 3));            // many ties
        1:       w = weight_t'(16'hFFF0 | $urandom_range(0, 15));
        default: w = weight_t'($urandom);
      endcase
      send_record(amount_t'($urandom), w, k == n - 1);
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    bit stalls_on;
    out_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!pressure_done && sb.checked >= 30 && out_if.valid) begin
        pressure_done = 1'b1;
        repeat (400) begin
          out_if.ready <= 1'b0;
          @(negedge clk);
        end
      end else begin
        stalls_on = !(sb.checked >= 150 && sb.checked < 260);
        out_if.ready <= !(stalls_on && $urandom_range(0, 99) < 18);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.out_amount, out_if.out_weight, out_if.source_slot,
                      out_if.end_of_run);
  end

  initial begin
    int n;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.amount      = '0;
    in_if.weight      = '0;
    in_if.last_record = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-record sets at both extremes
    send_record(16'hFFFF, 16'hFFFF, 1'b1);
    send_record(16'h0000, 16'h0000, 1'b1);
    // all weights equal: arrival order must survive
    send_record(16'h0001, 16'h0005, 1'b0);
    send_record(16'h0002, 16'h0005, 1'b0);
    send_record(16'h0003, 16'h0005, 1'b0);
    send_record(16'h0004, 16'h0005, 1'b1);
    // mixed extremes with a duplicated maximum
    send_record(16'hFFFF, 16'h0000, 1'b0);
    send_record(16'h0000, 16'hFFFF, 1'b0);
    send_record(16'hAAAA, 16'h8000, 1'b0);
    send_record(16'h5555, 16'hFFFF, 1'b0);
    send_record(16'h8000, 16'h0001, 1'b1);
    // already descending, then ascending
    send_record(16'h0010, 16'h0300, 1'b0);
    send_record(16'h0020, 16'h0200, 1'b0);
    send_record(16'h0030, 16'h0100, 1'b1);
    send_record(16'h0040, 16'h0100, 1'b0);
    send_record(16'h0050, 16'h0200, 1'b0);
    send_record(16'h0060, 16'h0300, 1'b1);

    // overfilled store, last marker on a dropped record
    send_random_set(REC_DEPTH + 3);
    while (items_sent < 340) begin
      if ($urandom_range(0, 99) < 6) n = $urandom_range(REC_DEPTH - 4, REC_DEPTH + 4);
      else                           n = $urandom_range(1, 10);
      send_random_set(n);
    end
    in_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
